[sv/stereo_bass_surround_fir_splitter_assert.svh]
// Assertion macros for the stereo bass splitter.
// Included by the top level; depends on nothing else.
`ifndef STEREO_BASS_SURROUND_FIR_SPLITTER_ASSERT_SVH
`define STEREO_BASS_SURROUND_FIR_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, suspended while reset is held
`define SBS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sbs assertion failed");
// Clocked check that also runs through reset
`define SBS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sbs assertion failed");
`else
`define SBS_ASSERT(lbl, clk, rstn, prop)
`define SBS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[sv/sbs_pkg.sv]
// Shared types, constants and coefficient functions for the stereo bass splitter.
// No dependencies.
package sbs_pkg;

    localparam int HIGHPASS_TAPS_DEF = 201;
    localparam int LOWPASS_TAPS_DEF  = 200;
    localparam int COEF_BITS_DEF     = 24;
    localparam int HP_DESIGN         = 201;
    localparam int LP_DESIGN         = 200;

    // Bass trims in Q1.15
    localparam logic [15:0] GAIN_M3_8DB = 16'd21157;
    localparam logic [15:0] GAIN_M9_4DB = 16'd11103;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK = 2'd1;

    // Handshake from the sequencer into the MAC
    typedef struct packed {
        logic valid;
        logic first;
    } mac_ctl_t;

    // Half designs in millionths: high-pass symmetric about the last entry, low-pass mirrored after it
    localparam int HP_HALF [101] = '{
        66, -143, -261, -202, 0, 216, 296, 173, -85, -308,
        -335, -123, 203, 423, 363, 32, -367, -551, -358, 122,
        578, 674, 290, -356, -828, -758, -126, 678, 1091, 763,
        -160, -1080, -1327, -643, 588, 1536, 1482, 352, -1158, -2000,
        -1492, 145, 1853, 2408, 1290, -871, -2627, -2676, -810, 1822,
        3408, 2708, 0, -2970, -4100, -2405, 1172, 4251, 4582, 1668,
        -2714, -5570, -4714, -407, 4601, 6796, 4341, -1457, -6775, -7764,
        -3290, 3990, 9149, 8275, 1366, -7264, -11609, -8076, 1689, 11387,
        14023, 6820, -6283, -16595, -16249, -3932, 13235, 23509, 18151, -1841,
        -24685, -34055, -19607, 14455, 48614, 56773, 20521, -58827, -157650, -239264,
        729167
    };

    localparam int LP_HALF [100] = '{
        247, 250, 187, 70, -72, -204, -290, -303, -233, -90,
        95, 273, 396, 420, 327, 127, -136, -395, -575, -612,
        -478, -186, 198, 577, 838, 892, 694, 270, -286, -829,
        -1201, -1272, -985, -381, 403, 1164, 1678, 1770, 1366, 527,
        -555, -1595, -2292, -2409, -1853, -712, 748, 2144, 3072, 3221,
        2472, 948, -993, -2842, -4065, -4255, -3261, -1249, 1307, 3737,
        5342, 5590, 4283, 1641, -1717, -4913, -7028, -7363, -5649, -2168,
        2275, 6523, 9361, 9841, 7580, 2922, -3082, -8890, -12842, -13603,
        -10568, -4114, 4385, 12809, 18765, 20200, 15986, 6358, -6949, -20899,
        -31700, -35577, -29625, -12552, 14875, 49786, 87600, 122809, 149975, 164760
    };

    // Millionths to Q1.(cb-1), rounded half up; elaboration only
    function automatic longint to_coef(input int m, input int cb);
        longint p;
        p = longint'(m) * (longint'(1) << (cb - 1));
        if (p >= 0) return (p + 64'sd500000) / 64'sd1000000;
        return -((-p + 64'sd499999) / 64'sd1000000);
    endfunction

    function automatic longint hp_coef(input int i, input int cb);
        if (i >= HP_DESIGN) return 64'sd0;
        return to_coef(HP_HALF[(i <= 100) ? i : (HP_DESIGN - 1 - i)], cb);
    endfunction

    function automatic longint lp_coef(input int i, input int cb);
        if (i >= LP_DESIGN) return 64'sd0;
        return to_coef(LP_HALF[(i < 100) ? i : (LP_DESIGN - 1 - i)], cb);
    endfunction

    // Saturation of a wide signed value
    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)  return 16'sh7fff;
        if (v < -64'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [63:0] v);
        if (v > 64'sd131071)  return 18'sh1ffff;
        if (v < -64'sd131072) return 18'sh20000;
        return v[17:0];
    endfunction

endpackage

[sv/sbs_hist_ram.sv]
// Sample history memory: one write port, one registered read port.
// No dependencies.
module sbs_hist_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 400
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/sbs_coef_rom.sv]
// High-pass and low-pass coefficient tables with registered read.
// Depends on sbs_pkg for the coefficient functions.
module sbs_coef_rom #(
    parameter int HIGHPASS_TAPS = sbs_pkg::HIGHPASS_TAPS_DEF,
    parameter int LOWPASS_TAPS  = sbs_pkg::LOWPASS_TAPS_DEF,
    parameter int COEF_BITS     = sbs_pkg::COEF_BITS_DEF,
    localparam int TMAX = (HIGHPASS_TAPS > LOWPASS_TAPS) ? HIGHPASS_TAPS : LOWPASS_TAPS,
    localparam int KW   = $clog2(TMAX)
) (
    input  logic                        aclk,
    input  logic                        sel_hp,
    input  logic [KW-1:0]               idx,
    output logic signed [COEF_BITS-1:0] coef
);

    logic signed [COEF_BITS-1:0] hp_tab [HIGHPASS_TAPS];
    logic signed [COEF_BITS-1:0] lp_tab [LOWPASS_TAPS];

    // Tables are built at elaboration
    for (genvar i = 0; i < HIGHPASS_TAPS; i++) begin : g_hp
        assign hp_tab[i] = COEF_BITS'(sbs_pkg::hp_coef(i, COEF_BITS));
    end
    for (genvar i = 0; i < LOWPASS_TAPS; i++) begin : g_lp
        assign lp_tab[i] = COEF_BITS'(sbs_pkg::lp_coef(i, COEF_BITS));
    end

    always_ff @(posedge aclk) begin
        if (sel_hp) begin
            coef <= (32'(idx) < HIGHPASS_TAPS) ? hp_tab[idx] : '0;
        end else begin
            coef <= (32'(idx) < LOWPASS_TAPS) ? lp_tab[idx] : '0;
        end
    end

endmodule

[sv/sbs_mac.sv]
// Shared multiply-accumulate: registered product, then accumulate.
// Depends on sbs_pkg for the control struct.
module sbs_mac #(
    parameter int AW    = 28,
    parameter int BW    = 18,
    parameter int ACC_W = 55
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sbs_pkg::mac_ctl_t       ctl,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [ACC_W-1:0] acc,
    output logic                    busy
);

    logic signed [AW+BW-1:0] prod_reg;
    logic                    pv_reg;
    logic                    pfirst_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    // Product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= ctl.valid;
        end
        prod_reg   <= a * b;
        pfirst_reg <= ctl.first;
    end

    // Accumulate stage; first beat of a pass reloads
    always_comb begin
        acc_next = acc_reg;
        if (pv_reg) begin
            acc_next = pfirst_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = pv_reg;

endmodule

[sv/stereo_bass_surround_fir_splitter.sv]
// Top level of the stereo bass splitter: sequencer, history memories, shared MAC.
// Depends on sbs_pkg, sbs_hist_ram, sbs_coef_rom, sbs_mac and the assertion header.
//
// One stereo frame in, one five-channel frame out. All multiplies run on one
// multiply-accumulate unit driven by a step sequencer: per channel a gain product,
// the high-pass FIR (HIGHPASS_TAPS taps), two low-pass FIRs (LOWPASS_TAPS taps
// each) and two bass trim products, each step followed by a pipeline drain and a
// write-back. Frame throughput is bounded by the single MAC. s_tready is high
// only between frames; a finished frame waits in the output register while the
// next one is taken. After reset a clearing pass zeroes the histories before
// the first frame is accepted.
`include "stereo_bass_surround_fir_splitter_assert.svh"

module stereo_bass_surround_fir_splitter #(
    parameter int HIGHPASS_TAPS = sbs_pkg::HIGHPASS_TAPS_DEF,
    parameter int LOWPASS_TAPS  = sbs_pkg::LOWPASS_TAPS_DEF,
    parameter int COEF_BITS     = sbs_pkg::COEF_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input frames
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // left_sample, right_sample
    // Output frames
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [79:0]                    m_tdata,   // front_left, front_right,
                                                      // surround_left, surround_right,
                                                      // subwoofer
    // Configuration
    input  logic                           cfg_we,
    input  logic [sbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data
);

    localparam int DH    = HIGHPASS_TAPS - 1;
    localparam int DL    = LOWPASS_TAPS - 1;
    localparam int HDEP  = 2 * DH;
    localparam int LDEP  = 4 * DL;
    localparam int HAW   = $clog2(HDEP);
    localparam int LAW   = $clog2(LDEP);
    localparam int DMAX  = (DH > DL) ? DH : DL;
    localparam int IW    = $clog2(DMAX);
    localparam int TMAX  = (HIGHPASS_TAPS > LOWPASS_TAPS) ? HIGHPASS_TAPS : LOWPASS_TAPS;
    localparam int KW    = $clog2(TMAX);
    localparam int AW    = (COEF_BITS > 28) ? COEF_BITS : 28;
    localparam int BW    = 18;
    localparam int ACC_W = AW + BW + 9;
    localparam int CMAX  = (HDEP > LDEP) ? HDEP : LDEP;
    localparam int CW    = $clog2(CMAX + 1);

    localparam logic signed [ACC_W-1:0] HALF_C  = ACC_W'(1) << (COEF_BITS - 2);
    localparam logic signed [ACC_W-1:0] HALF_15 = ACC_W'(1) << 14;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_POST  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Steps of one channel
    localparam logic [2:0] STEP_GAIN = 3'd0;
    localparam logic [2:0] STEP_HP   = 3'd1;
    localparam logic [2:0] STEP_LPR  = 3'd2;
    localparam logic [2:0] STEP_SCR  = 3'd3;
    localparam logic [2:0] STEP_LPH  = 3'd4;
    localparam logic [2:0] STEP_SCH  = 3'd5;

    // MAC operand sources
    localparam logic [1:0] SRC_OP = 2'd0;
    localparam logic [1:0] SRC_X  = 2'd1;
    localparam logic [1:0] SRC_HP = 2'd2;
    localparam logic [1:0] SRC_LP = 2'd3;

    logic [2:0]              state_reg, state_next;
    logic [2:0]              step_reg, step_next;
    logic                    ch_reg, ch_next;
    logic [KW-1:0]           k_reg, k_next;
    logic [IW-1:0]           rd_idx_reg, rd_idx_next;
    logic [IW-1:0]           hp_ptr_reg, hp_ptr_next;
    logic [IW-1:0]           lp_ptr_reg, lp_ptr_next;
    logic [CW-1:0]           clr_reg, clr_next;
    logic [15:0]             gain_reg;
    logic [4:0]              mask_reg;
    logic signed [15:0]      right_reg, right_next;
    logic signed [AW-1:0]    opa_reg, opa_next;
    logic signed [BW-1:0]    opb_reg, opb_next;
    logic signed [17:0]      x_reg, x_next;
    logic signed [15:0]      g_reg, g_next;
    logic signed [17:0]      hp_reg, hp_next;
    logic signed [AW-1:0]    braw_reg, braw_next;
    logic signed [15:0]      front_reg [2];
    logic signed [15:0]      sur_reg [2];
    logic signed [15:0]      sub_reg;
    logic                    f_valid_reg, f_valid_next;
    logic                    f_first_reg, f_first_next;
    logic [1:0]              f_src_reg, f_src_next;
    logic                    m_tvalid_reg;
    logic [79:0]             m_tdata_reg;

    logic [KW:0]             n_ops;
    logic [IW-1:0]           dep_last;
    logic [IW-1:0]           start_idx;
    logic                    hp_we, lp_we;
    logic [HAW-1:0]          hp_waddr, hp_raddr;
    logic [LAW-1:0]          lp_waddr, lp_raddr;
    logic [15:0]             hp_wdata, hp_rdata;
    logic [17:0]             lp_wdata, lp_rdata;
    logic signed [COEF_BITS-1:0] coef;
    sbs_pkg::mac_ctl_t       mac_ctl;
    logic signed [AW-1:0]    mac_a;
    logic signed [BW-1:0]    mac_b;
    logic signed [ACC_W-1:0] acc;
    logic                    mac_busy;
    logic signed [ACC_W-1:0] acc_c, acc_15;
    logic signed [AW:0]      front_sum;
    logic                    out_free;
    logic [HAW-1:0]          hp_base;
    logic [LAW-1:0]          lp_base;

    // History and coefficient storage
    sbs_hist_ram #(.WIDTH(16), .DEPTH(HDEP)) u_hp_ram (
        .aclk(aclk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
        .raddr(hp_raddr), .rdata(hp_rdata)
    );

    sbs_hist_ram #(.WIDTH(18), .DEPTH(LDEP)) u_lp_ram (
        .aclk(aclk), .we(lp_we), .waddr(lp_waddr), .wdata(lp_wdata),
        .raddr(lp_raddr), .rdata(lp_rdata)
    );

    sbs_coef_rom #(
        .HIGHPASS_TAPS(HIGHPASS_TAPS), .LOWPASS_TAPS(LOWPASS_TAPS), .COEF_BITS(COEF_BITS)
    ) u_rom (
        .aclk(aclk), .sel_hp(step_reg == STEP_HP), .idx(k_reg), .coef(coef)
    );

    // Operand select for the beat leaving the fetch stage
    always_comb begin
        mac_ctl.valid = f_valid_reg;
        mac_ctl.first = f_first_reg;
        mac_a = (f_src_reg == SRC_OP) ? opa_reg : AW'(coef);
        case (f_src_reg)
            SRC_OP:  mac_b = opb_reg;
            SRC_X:   mac_b = x_reg;
            SRC_HP:  mac_b = {{2{hp_rdata[15]}}, hp_rdata};
            SRC_LP:  mac_b = lp_rdata;
            default: mac_b = opb_reg;
        endcase
    end

    sbs_mac #(.AW(AW), .BW(BW), .ACC_W(ACC_W)) u_mac (
        .aclk(aclk), .aresetn(aresetn), .ctl(mac_ctl), .a(mac_a), .b(mac_b),
        .acc(acc), .busy(mac_busy)
    );

    // Step length and history geometry
    always_comb begin
        case (step_reg)
            STEP_HP:  n_ops = (KW + 1)'(HIGHPASS_TAPS);
            STEP_LPR: n_ops = (KW + 1)'(LOWPASS_TAPS);
            STEP_LPH: n_ops = (KW + 1)'(LOWPASS_TAPS);
            default:  n_ops = (KW + 1)'(1);
        endcase
        if (step_reg == STEP_HP) begin
            dep_last  = IW'(DH - 1);
            start_idx = (hp_ptr_reg == '0) ? IW'(DH - 1) : hp_ptr_reg - 1'b1;
        end else begin
            dep_last  = IW'(DL - 1);
            start_idx = (lp_ptr_reg == '0) ? IW'(DL - 1) : lp_ptr_reg - 1'b1;
        end
        hp_base = ch_reg ? HAW'(DH) : '0;
        case ({ch_reg, step_reg == STEP_LPH})
            2'b00:   lp_base = '0;
            2'b01:   lp_base = LAW'(DL);
            2'b10:   lp_base = LAW'(2 * DL);
            2'b11:   lp_base = LAW'(3 * DL);
            default: lp_base = '0;
        endcase
        hp_raddr = hp_base + HAW'(rd_idx_reg);
        lp_raddr = lp_base + LAW'(rd_idx_reg);
    end

    // Rounded views of the accumulator, and the front sum
    always_comb begin
        acc_c     = (acc + HALF_C) >>> (COEF_BITS - 1);
        acc_15    = (acc + HALF_15) >>> 15;
        front_sum = (AW + 1)'(acc_15) + (AW + 1)'(braw_reg);
    end

    // History writes: clearing pass, or write-back after a FIR
    always_comb begin
        hp_we    = 1'b0;
        lp_we    = 1'b0;
        hp_waddr = hp_base + HAW'(hp_ptr_reg);
        lp_waddr = lp_base + LAW'(lp_ptr_reg);
        hp_wdata = g_reg;
        lp_wdata = (step_reg == STEP_LPH) ? hp_reg : {{2{g_reg[15]}}, g_reg};
        if (state_reg == S_CLEAR) begin
            hp_we    = (32'(clr_reg) < HDEP);
            lp_we    = (32'(clr_reg) < LDEP);
            hp_waddr = HAW'(clr_reg);
            lp_waddr = LAW'(clr_reg);
            hp_wdata = '0;
            lp_wdata = '0;
        end else if (state_reg == S_POST) begin
            hp_we = (step_reg == STEP_HP);
            lp_we = (step_reg == STEP_LPR) || (step_reg == STEP_LPH);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        ch_next      = ch_reg;
        k_next       = k_reg;
        rd_idx_next  = rd_idx_reg;
        hp_ptr_next  = hp_ptr_reg;
        lp_ptr_next  = lp_ptr_reg;
        clr_next     = clr_reg;
        right_next   = right_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        x_next       = x_reg;
        g_next       = g_reg;
        hp_next      = hp_reg;
        braw_next    = braw_reg;
        f_valid_next = 1'b0;
        f_first_next = 1'b0;
        f_src_next   = SRC_OP;
        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CMAX - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    opa_next   = AW'($signed(s_tdata[15:0]));
                    opb_next   = {2'b00, gain_reg};
                    right_next = s_tdata[31:16];
                    ch_next    = 1'b0;
                    step_next  = STEP_GAIN;
                    k_next     = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                f_valid_next = 1'b1;
                f_first_next = (k_reg == '0);
                if ((step_reg == STEP_GAIN) || (step_reg == STEP_SCR) ||
                    (step_reg == STEP_SCH)) begin
                    f_src_next = SRC_OP;
                end else if (k_reg == '0) begin
                    f_src_next = SRC_X;
                end else begin
                    f_src_next = (step_reg == STEP_HP) ? SRC_HP : SRC_LP;
                end
                // Walk the circular history from newest to oldest
                if (k_reg == '0) begin
                    rd_idx_next = start_idx;
                end else begin
                    rd_idx_next = (rd_idx_reg == '0) ? dep_last : rd_idx_reg - 1'b1;
                end
                if ((KW + 1)'(k_reg) == n_ops - 1'b1) begin
                    k_next     = '0;
                    state_next = S_DRAIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!f_valid_reg && !mac_busy) begin
                    state_next = S_POST;
                end
            end
            S_POST: begin
                state_next = S_ISSUE;
                case (step_reg)
                    STEP_GAIN: begin
                        g_next    = sbs_pkg::sat16(64'(acc_15));
                        x_next    = 18'(sbs_pkg::sat16(64'(acc_15)));
                        step_next = STEP_HP;
                    end
                    STEP_HP: begin
                        hp_next   = sbs_pkg::sat18(64'(acc_c));
                        x_next    = 18'(g_reg);
                        step_next = STEP_LPR;
                    end
                    STEP_LPR: begin
                        opa_next  = AW'(acc_c);
                        opb_next  = BW'(sbs_pkg::GAIN_M9_4DB);
                        step_next = STEP_SCR;
                    end
                    STEP_SCR: begin
                        braw_next = AW'(acc_15);
                        x_next    = hp_reg;
                        step_next = STEP_LPH;
                    end
                    STEP_LPH: begin
                        opa_next  = AW'(acc_c);
                        opb_next  = BW'(sbs_pkg::GAIN_M3_8DB);
                        step_next = STEP_SCH;
                    end
                    STEP_SCH: begin
                        if (!ch_reg) begin
                            ch_next   = 1'b1;
                            opa_next  = AW'(right_reg);
                            opb_next  = {2'b00, gain_reg};
                            step_next = STEP_GAIN;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    hp_ptr_next = (hp_ptr_reg == IW'(DH - 1)) ? '0 : hp_ptr_reg + 1'b1;
                    lp_ptr_next = (lp_ptr_reg == IW'(DL - 1)) ? '0 : lp_ptr_reg + 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            step_reg     <= STEP_GAIN;
            ch_reg       <= 1'b0;
            k_reg        <= '0;
            rd_idx_reg   <= '0;
            hp_ptr_reg   <= '0;
            lp_ptr_reg   <= '0;
            clr_reg      <= '0;
            f_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            gain_reg     <= 16'd32768;
            mask_reg     <= 5'd31;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            ch_reg      <= ch_next;
            k_reg       <= k_next;
            rd_idx_reg  <= rd_idx_next;
            hp_ptr_reg  <= hp_ptr_next;
            lp_ptr_reg  <= lp_ptr_next;
            clr_reg     <= clr_next;
            f_valid_reg <= f_valid_next;
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                if (cfg_index == sbs_pkg::REG_INPUT_GAIN) begin
                    gain_reg <= cfg_data;
                end
                if (cfg_index == sbs_pkg::REG_CHANNEL_MASK) begin
                    mask_reg <= cfg_data[4:0];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        right_reg   <= right_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        x_reg       <= x_next;
        g_reg       <= g_next;
        hp_reg      <= hp_next;
        braw_reg    <= braw_next;
        f_first_reg <= f_first_next;
        f_src_reg   <= f_src_next;
        if (state_reg == S_POST && step_reg == STEP_HP) begin
            sur_reg[ch_reg] <= sbs_pkg::sat16(64'(sbs_pkg::sat18(64'(acc_c))));
        end
        if (state_reg == S_POST && step_reg == STEP_SCR && !ch_reg) begin
            sub_reg <= sbs_pkg::sat16(64'(acc_15));
        end
        if (state_reg == S_POST && step_reg == STEP_SCH) begin
            front_reg[ch_reg] <= sbs_pkg::sat16(64'(front_sum));
        end
        if (state_reg == S_DONE && out_free) begin
            m_tdata_reg <= {mask_reg[4] ? sub_reg    : 16'sd0,
                            mask_reg[3] ? sur_reg[1]   : 16'sd0,
                            mask_reg[2] ? sur_reg[0]   : 16'sd0,
                            mask_reg[1] ? front_reg[1] : 16'sd0,
                            mask_reg[0] ? front_reg[0] : 16'sd0};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `SBS_ASSERT(a_idle_pipe_empty, aclk, aresetn, s_tready |-> (!f_valid_reg && !mac_busy))
    `SBS_ASSERT(a_post_after_drain, aclk, aresetn, (state_reg == S_POST) |-> (!f_valid_reg && !mac_busy))
    `SBS_ASSERT(a_tap_in_range, aclk, aresetn, (state_reg == S_ISSUE) |-> ((KW + 1)'(k_reg) < n_ops))
    `SBS_ASSERT_ALWAYS(a_no_accept_in_reset, aclk, !aresetn |=> !s_tready)

endmodule

[verif/stereo_bass_surround_fir_splitter_test.sv]
// Self-checking testbench for the stereo bass splitter: stream traffic with a
// bit-exact predictor. Depends on sbs_pkg and the stereo_bass_surround_fir_splitter RTL.
`timescale 1ns / 100ps

module stereo_bass_surround_fir_splitter_test;

    localparam int HP_N = sbs_pkg::HIGHPASS_TAPS_DEF;
    localparam int LP_N = sbs_pkg::LOWPASS_TAPS_DEF;
    localparam int CB = sbs_pkg::COEF_BITS_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 1400;
    localparam logic [sbs_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    // Expected-frame store and bass/surround predictor
    class splitter_scoreboard;
        longint hp_c[HP_N];
        longint lp_c[LP_N];
        longint hp_hist[2][HP_N-1];
        longint lp_hist[4][LP_N-1];
        bit [15:0] gain;
        bit [4:0] mask;
        bit [79:0] frames_due[$];
        int errors;
        int checked;

        function longint q_coef(int m);
            longint p;
            p = longint'(m) * (longint'(1) << (CB - 1));
            if (p >= 0) return (p + 500000) / 1000000;
            return -((-p + 499999) / 1000000);
        endfunction

        function new();
            for (int i = 0; i < HP_N; i++)
                hp_c[i] = q_coef(sbs_pkg::HP_HALF[(i <= 100) ? i : (HP_N - 1 - i)]);
            for (int i = 0; i < LP_N; i++)
                lp_c[i] = q_coef(sbs_pkg::LP_HALF[(i < 100) ? i : (LP_N - 1 - i)]);
            foreach (hp_hist[c, k]) hp_hist[c][k] = 0;
            foreach (lp_hist[c, k]) lp_hist[c][k] = 0;
            gain = 16'd32768;
            mask = 5'd31;
            errors = 0;
            checked = 0;
        endfunction

        function longint rshift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clip(longint v, int bits);
            longint hi;
            hi = (longint'(1) << (bits - 1)) - 1;
            return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
        endfunction

        function longint hp_fir(int c, longint x);
            longint acc;
            acc = hp_c[0] * x;
            for (int k = 1; k < HP_N; k++) acc += hp_c[k] * hp_hist[c][k-1];
            for (int k = HP_N - 2; k > 0; k--) hp_hist[c][k] = hp_hist[c][k-1];
            hp_hist[c][0] = x;
            return rshift(acc, CB - 1);
        endfunction

        function longint lp_fir(int c, longint x);
            longint acc;
            acc = lp_c[0] * x;
            for (int k = 1; k < LP_N; k++) acc += lp_c[k] * lp_hist[c][k-1];
            for (int k = LP_N - 2; k > 0; k--) lp_hist[c][k] = lp_hist[c][k-1];
            lp_hist[c][0] = x;
            return rshift(acc, CB - 1);
        endfunction

        function void set_reg(logic [sbs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx == sbs_pkg::REG_INPUT_GAIN) gain = val;
            else if (idx == sbs_pkg::REG_CHANNEL_MASK) mask = val[4:0];
        endfunction

        // One accepted stereo beat -> one expected five-channel frame
        function void note_frame(logic [31:0] d);
            longint res[5];
            longint g, hp, raw, lph, braw, bhp;
            bit [79:0] f;
            for (int c = 0; c < 2; c++) begin
                g = clip(rshift(longint'($signed(d[16*c +: 16])) * longint'(gain), 15), 16);
                hp = clip(hp_fir(c, g), 18);
                raw = lp_fir(2 * c, g);
                lph = lp_fir(2 * c + 1, hp);
                braw = rshift(raw * longint'(sbs_pkg::GAIN_M9_4DB), 15);
                bhp = rshift(lph * longint'(sbs_pkg::GAIN_M3_8DB), 15);
                res[c] = clip(bhp + braw, 16);
                res[2 + c] = clip(hp, 16);
                if (c == 0) res[4] = clip(braw, 16);
            end
            for (int j = 0; j < 5; j++) f[16*j +: 16] = mask[j] ? res[j][15:0] : 16'd0;
            frames_due.push_back(f);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH frame %0d: %s", checked, msg);
            errors++;
        endtask

        task check_frame(logic [79:0] got);
            string chan[5] = '{"front_left", "front_right", "surround_left",
                               "surround_right", "subwoofer"};
            bit [79:0] want;
            if (frames_due.size() == 0) begin
                report_mismatch($sformatf("unexpected output %h", got));
            end else begin
                want = frames_due.pop_front();
                for (int j = 0; j < 5; j++)
                    if (got[16*j +: 16] !== want[16*j +: 16])
                        report_mismatch($sformatf("%s got %h want %h", chan[j],
                                        got[16*j +: 16], want[16*j +: 16]));
            end
            checked++;
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [sbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    splitter_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;
    int stall_style = 0;
    bit long_hold = 1'b0;
    int sent = 0;

    stereo_bass_surround_fir_splitter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("stereo_bass_surround_fir_splitter verification failed");
            $finish;
        end
    end

    // Output side: stall pattern, one long hold on request
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                for (hold = 0; hold < 5000; hold++) @(negedge aclk);
                long_hold = 1'b0;
            end
            case (stall_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(99) < 60);
                default: m_tready <= ((cycles % 11) > 6);
            endcase
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_frame(m_tdata);

    // One stereo beat, bursts with random gaps in between
    task send_frame(logic [15:0] left, logic [15:0] right);
        int gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(40);
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {right, left};
        do @(posedge aclk); while (!s_tready);
        sb.note_frame(s_tdata);
        sent++;
        @(negedge aclk);
    endtask

    // Register write once the block has drained
    task write_reg(logic [sbs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        s_tvalid <= 1'b0;
        burst_left = 0;
        wait (sb.frames_due.size() == 0);
        repeat (20) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function logic [15:0] pick_sample();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'($urandom);
            4, 5: return 16'($urandom_range(4000) - 2000);
            6: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            7: return 16'(1 << $urandom_range(15));
            default: return 16'($urandom_range(20000) - 10000);
        endcase
    endfunction

    task random_phase(int n);
        repeat (n) send_frame(pick_sample(), pick_sample());
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: impulses, full-scale steps, alternating extremes
        stall_style = 0;
        send_frame(16'h7fff, 16'h8000);
        repeat (3) send_frame(16'h0000, 16'h0000);
        send_frame(16'h8000, 16'h7fff);
        repeat (4) send_frame(16'h7fff, 16'h7fff);
        repeat (4) send_frame(16'h8000, 16'h8000);
        for (int i = 0; i < 6; i++)
            send_frame(i[0] ? 16'h7fff : 16'h8000, i[0] ? 16'h8000 : 16'h7fff);
        send_frame(16'h0001, 16'hffff);

        // Gain above unity saturates the gained sample; spare index is ignored
        write_reg(sbs_pkg::REG_INPUT_GAIN, 16'hffff);
        write_reg(REG_SPARE, 16'h1234);
        send_frame(16'h7fff, 16'h8000);
        send_frame(16'h4000, 16'hc000);
        stall_style = 1;
        random_phase(80);

        // Zero gain, receiver held off long enough to back up the input
        write_reg(sbs_pkg::REG_INPUT_GAIN, 16'h0000);
        long_hold = 1'b1;
        random_phase(40);

        // Unity gain, all outputs masked
        write_reg(sbs_pkg::REG_INPUT_GAIN, 16'h8000);
        write_reg(sbs_pkg::REG_CHANNEL_MASK, 16'h0000);
        stall_style = 2;
        random_phase(60);

        // Random settings
        for (int p = 0; p < 4; p++) begin
            write_reg(sbs_pkg::REG_CHANNEL_MASK, 16'($urandom_range(31)));
            write_reg(sbs_pkg::REG_INPUT_GAIN, 16'($urandom));
            stall_style = p % 3;
            random_phase(40);
        end

        // Back to defaults, full mask
        write_reg(sbs_pkg::REG_CHANNEL_MASK, 16'h001f);
        write_reg(sbs_pkg::REG_INPUT_GAIN, 16'h8000);
        stall_style = 1;
        random_phase(100);

        s_tvalid <= 1'b0;
        wait (sb.frames_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d stereo beats over gain 0/unity/max and masked settings,", sent);
        $display("checked %0d output frames in %0d cycles.", sb.checked, cycles);
        if (sb.errors == 0 && sb.frames_due.size() == 0)
            $display("stereo_bass_surround_fir_splitter verification clean");
        else
            $display("stereo_bass_surround_fir_splitter verification failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/sbs_pkg.sv
sv/sbs_hist_ram.sv
sv/sbs_coef_rom.sv
sv/sbs_mac.sv
sv/stereo_bass_surround_fir_splitter.sv
verif/stereo_bass_surround_fir_splitter_test.sv
